/* src/etd_pkg.sv */
// ----------------------------------------------------------------------------
// etd_pkg
// Shared types and constants for the event and timeout task dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package etd_pkg;

  // Sizing
  localparam int TASKS      = 16;
  localparam int MODES      = 4;
  localparam int EVENT_BITS = 32;
  localparam int TASK_W     = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  typedef enum logic [1:0] {
    OP_POST     = 2'd0,
    OP_TICK     = 2'd1,
    OP_SET_WAIT = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_MODE = 3'd0,
    REG_MODE_EN0 = 3'd1,
    REG_MODE_EN1 = 3'd2,
    REG_MODE_EN2 = 3'd3,
    REG_MODE_EN3 = 3'd4
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  task_id;
    logic [31:0] event_mask;
    logic [15:0] timeout;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [3:0] task_id_out;
    logic       task_valid;
    logic       last;
  } res_t;

  // Per-task update from the shared scan unit
  typedef struct packed {
    logic [EVENT_BITS-1:0] mask;
    logic [TICK_W-1:0]     timeout;
    logic                  woke;
  } scan_t;

endpackage

`default_nettype wire

/* src/etd_scan_unit.sv */
// ----------------------------------------------------------------------------
// etd_scan_unit
// Shared compare and subtract unit: applies pending events and ticks to the
// wait state of the task currently selected by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module etd_scan_unit (
  input  wire logic [etd_pkg::EVENT_BITS-1:0] mask_i,
  input  wire logic [etd_pkg::TICK_W-1:0]     timeout_i,
  input  wire logic [etd_pkg::EVENT_BITS-1:0] pend_events_i,
  input  wire logic [etd_pkg::TICK_W-1:0]     pend_ticks_i,
  output etd_pkg::scan_t                      upd_o
);
  import etd_pkg::*;

  logic              hit;
  logic [TICK_W:0]   diff;
  logic              expire;

  // Event hit, else countdown with expiry on borrow or zero
  always_comb begin
    hit    = |(mask_i & pend_events_i);
    diff   = {1'b0, timeout_i} - {1'b0, pend_ticks_i};
    expire = diff[TICK_W] || (diff[TICK_W-1:0] == '0);
    upd_o.mask    = mask_i;
    upd_o.timeout = timeout_i;
    upd_o.woke    = 1'b0;
    if (hit) begin
      upd_o.mask    = mask_i & ~pend_events_i;
      upd_o.timeout = '0;
      upd_o.woke    = 1'b1;
    end else if ((pend_ticks_i != '0) && (timeout_i != '0)) begin
      if (expire) begin
        upd_o.mask    = '0;
        upd_o.timeout = '0;
        upd_o.woke    = 1'b1;
      end else begin
        upd_o.timeout = diff[TICK_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* src/event_timeout_task_dispatcher.sv */
// ----------------------------------------------------------------------------
// event_timeout_task_dispatcher
// Round-robin task dispatcher driven by posted events and tick timeouts.
//
//   Channel   Signals                                  Direction  Handshake
//   command   start, busy, in_i                        in         start & !busy
//   result    result_valid_o, res_o                    out        strobe, no stall
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,   in         valid & ready
//             cfg_data_i
//
// Post, tick and set-wait take effect at the accepting edge; busy stays low.
// Dispatch holds busy while every task is scanned (one task a cycle through
// the shared compare/subtract unit) and then while the round-robin pointer
// walks the ready set, one result per cycle at most. Reset clears all state
// but the result payload. The receiver cannot stall; config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module event_timeout_task_dispatcher (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command
  input  wire logic                         start,
  output logic                              busy,
  input  wire etd_pkg::in_t                 in_i,
  // results
  output logic                              result_valid_o,
  output etd_pkg::res_t                     res_o,
  // configuration
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [etd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [etd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import etd_pkg::*;

  // Configuration registers
  logic [1:0]       run_mode_q;
  logic [TASKS-1:0] mode_en_q [MODES];

  // Task state
  logic [EVENT_BITS-1:0] wait_q [TASKS];
  logic [TICK_W-1:0]     tmo_q  [TASKS];
  logic [TASKS-1:0]      ready_q, ready_d;
  logic [EVENT_BITS-1:0] pend_ev_q, pend_ev_d;
  logic [TICK_W-1:0]     pend_tk_q, pend_tk_d;
  logic [TASK_W-1:0]     ptr_q, ptr_d;
  logic [TASK_W-1:0]     cnt_q, cnt_d;
  state_e                state_q, state_d;

  // Output registers
  logic result_valid_q, result_valid_d;
  res_t res_q, res_d;

  // Decode
  logic                  accept;
  op_e                   op;
  logic [EVENT_BITS-1:0] evm;
  logic                  tid_ok;
  logic [TASK_W-1:0]     tid;
  logic [TASKS-1:0]      en;
  logic [TASKS-1:0]      runnable;
  logic [TASKS-1:0]      ptr_bit;
  logic [TASK_W-1:0]     ptr_next;
  scan_t                 upd;

  // Write enables for the task arrays
  logic                  scan_we, emit_we, set_we;

  assign accept   = start && !busy;
  assign op       = op_e'(in_i.opcode);
  assign evm      = EVENT_BITS'(in_i.event_mask);
  assign tid_ok   = 32'(in_i.task_id) < TASKS;
  assign tid      = TASK_W'(in_i.task_id);
  assign en       = (32'(run_mode_q) < MODES) ? mode_en_q[run_mode_q] : '0;
  assign runnable = ready_q & en;
  assign ptr_bit  = TASKS'(1) << ptr_q;
  assign ptr_next = (32'(ptr_q) == TASKS - 1) ? '0 : ptr_q + TASK_W'(1);

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = result_valid_q;
  assign res_o          = res_q;

  // Shared per-task update unit
  etd_scan_unit u_scan (
    .mask_i        (wait_q[cnt_q]),
    .timeout_i     (tmo_q[cnt_q]),
    .pend_events_i (pend_ev_q),
    .pend_ticks_i  (pend_tk_q),
    .upd_o         (upd)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && op == OP_DISPATCH) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (32'(cnt_q) == TASKS - 1) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (runnable == '0) begin
          state_d = ST_IDLE;
        end else if (((runnable & ptr_bit) != '0) &&
                     ((runnable & ~ptr_bit) == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    ready_d        = ready_q;
    pend_ev_d      = pend_ev_q;
    pend_tk_d      = pend_tk_q;
    ptr_d          = ptr_q;
    cnt_d          = cnt_q;
    result_valid_d = 1'b0;
    res_d          = res_q;
    scan_we        = 1'b0;
    emit_we        = 1'b0;
    set_we         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          unique case (op)
            OP_POST: pend_ev_d = pend_ev_q | evm;
            OP_TICK: begin
              if (pend_tk_q != '1) pend_tk_d = pend_tk_q + TICK_W'(1);
            end
            OP_SET_WAIT: begin
              if (tid_ok) begin
                set_we = 1'b1;
                if (evm == '0 && in_i.timeout == '0) begin
                  ready_d = ready_q | (TASKS'(1) << tid);
                end
              end
            end
            OP_DISPATCH: ;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        scan_we = 1'b1;
        if (upd.woke) ready_d = ready_q | (TASKS'(1) << cnt_q);
        cnt_d = cnt_q + TASK_W'(1);
        if (32'(cnt_q) == TASKS - 1) begin
          pend_ev_d = '0;
          pend_tk_d = '0;
          cnt_d     = '0;
        end
      end
      ST_EMIT: begin
        if (runnable == '0) begin
          // nothing to run: a single empty result
          result_valid_d    = 1'b1;
          res_d.task_id_out = '0;
          res_d.task_valid  = 1'b0;
          res_d.last        = 1'b1;
        end else begin
          ptr_d = ptr_next;
          if ((runnable & ptr_bit) != '0) begin
            emit_we           = 1'b1;
            ready_d           = ready_q & ~ptr_bit;
            result_valid_d    = 1'b1;
            res_d.task_id_out = 4'(ptr_q);
            res_d.task_valid  = 1'b1;
            res_d.last        = ((runnable & ~ptr_bit) == '0);
          end
        end
      end
      default: ;
    endcase
  end

  // Control and scalar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      ready_q        <= '0;
      pend_ev_q      <= '0;
      pend_tk_q      <= '0;
      ptr_q          <= '0;
      cnt_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      ready_q        <= ready_d;
      pend_ev_q      <= pend_ev_d;
      pend_tk_q      <= pend_tk_d;
      ptr_q          <= ptr_d;
      cnt_q          <= cnt_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Per-task wait masks and timeouts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASKS; i++) begin
        wait_q[i] <= '0;
        tmo_q[i]  <= '0;
      end
    end else begin
      if (set_we) begin
        wait_q[tid] <= evm;
        tmo_q[tid]  <= in_i.timeout;
      end
      if (scan_we) begin
        wait_q[cnt_q] <= upd.mask;
        tmo_q[cnt_q]  <= upd.timeout;
      end
      if (emit_we) begin
        wait_q[ptr_q] <= '0;
      end
    end
  end

  // Configuration write transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q <= '0;
      for (int m = 0; m < MODES; m++) mode_en_q[m] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      for (int m = 0; m < MODES; m++) begin
        if (32'(cfg_index_i) == 32'(REG_MODE_EN0) + m) begin
          mode_en_q[m] <= TASKS'(cfg_data_i);
        end
      end
      if (cfg_idx_e'(cfg_index_i) == REG_RUN_MODE) run_mode_q <= cfg_data_i[1:0];
    end
  end

endmodule

`default_nettype wire
